[rtl/core/rqs_pkg.sv]
// Package for the retransmit queue scheduler: widths, item kinds, outcome codes,
// the per-slot record and the chain signal types. No dependencies.
`timescale 1ns / 1ps
package rqs_pkg;

   localparam int DefaultDepth   = 16;
   localparam int SeqWidth       = 16;
   localparam int TagWidth       = 16;
   localparam int TimeWidth      = 32;
   localparam int CountWidth     = 8;
   localparam int IntervalWidth  = 16;
   localparam int OutcomeWidth   = 3;
   localparam int KindWidth      = 2;
   localparam int CsrIndexWidth  = 2;
   localparam int ResultCntWidth = 5;

   // Largest resend interval, and the largest deferral step that follows from it.
   localparam int MaxResendInterval = 65535;
   localparam int MaxHalfInterval   = MaxResendInterval >> 1;

   localparam logic [IntervalWidth-1:0] ResetResendInterval = 16'd5;
   localparam logic [CountWidth-1:0]    ResetMaxSendCount   = 8'd3;
   localparam logic [CountWidth-1:0]    ResetMaxFailCount   = 8'd3;

   typedef enum logic [KindWidth-1:0] {
      KIND_INSERT = 2'd0,
      KIND_ACK    = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [OutcomeWidth-1:0] {
      OUT_NONE        = 3'd0,
      OUT_DEFERRED    = 3'd1,
      OUT_SENT_KEPT   = 3'd2,
      OUT_SENT_REMOVE = 3'd3,
      OUT_SENDS_DONE  = 3'd4,
      OUT_FAIL_KEPT   = 3'd5,
      OUT_FAILS_DONE  = 3'd6
   } outcome_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_RESEND_INTERVAL = 2'd0,
      CSR_MAX_SEND_COUNT  = 2'd1,
      CSR_MAX_FAIL_COUNT  = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   // One table entry.
   typedef struct packed {
      logic [SeqWidth-1:0]   seq;
      logic [TagWidth-1:0]   tag;
      logic                  tcp;
      logic                  ack;
      logic [TimeWidth-1:0]  next_time;
      logic [CountWidth-1:0] sends;
      logic [CountWidth-1:0] fails;
   } entry_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic                     insert;
      logic                     ack;
      logic                     tick;
      logic [SeqWidth-1:0]      seq;
      logic [TimeWidth-1:0]     now;
      logic                     udp_ready;
      logic                     tcp_ready;
      logic                     send_ok;
      logic [TimeWidth-1:0]     defer_time;
      logic [TimeWidth-1:0]     resend_time;
      logic [CountWidth-1:0]    max_sends;
      logic [CountWidth-1:0]    max_fails;
   } cmd_type;

   // Status passed down the chain from one cell to the next.
   typedef struct packed {
      logic found;    // an earlier cell has taken the ack or the send
      logic remove;   // an earlier cell is being removed: shift up
   } link_type;

   // What each cell reports back for the result.
   typedef struct packed {
      logic                  deferred;
      logic                  sent;
      logic                  matched;
      logic [OutcomeWidth-1:0] outcome;
   } report_type;

endpackage

[rtl/core/rqs_cell.sv]
// One slot of the ordered table. It holds an entry, evaluates it against the
// broadcast command and the chain status, and shifts up on a removal. Uses rqs_pkg.
`timescale 1ns / 1ps
module rqs_cell
   import rqs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  cmd_type    cmd,
   input  link_type   link_in,
   input  logic       is_tail,
   input  entry_type  new_entry,
   input  logic       next_valid,
   input  entry_type  next_entry,
   output link_type   link_out,
   output logic       valid,
   output entry_type  entry,
   output report_type report
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      due, ready, take, hit, drop;
   logic [CountWidth-1:0] sends_inc, fails_inc;

   assign valid = valid_ff;
   assign entry = entry_ff;

   // Evaluate this slot against the command.
   always_comb begin
      due       = (entry_ff.next_time == '0) || (entry_ff.next_time < cmd.now);
      ready     = entry_ff.tcp ? cmd.tcp_ready : cmd.udp_ready;
      sends_inc = entry_ff.sends + 1'b1;
      fails_inc = entry_ff.fails + 1'b1;
      hit       = valid_ff && !link_in.found && cmd.ack && (entry_ff.seq == cmd.seq);
      take      = valid_ff && !link_in.found && cmd.tick && due && ready;
      report.deferred = valid_ff && !link_in.found && cmd.tick && due && !ready;
      report.sent     = take;
      report.matched  = hit;
      report.outcome  = OUT_NONE;
      drop = 1'b0;
      if (take) begin
         if (cmd.send_ok) begin
            if (entry_ff.ack) begin
               drop = (sends_inc >= cmd.max_sends);
               report.outcome = drop ? OUT_SENDS_DONE : OUT_SENT_KEPT;
            end else begin
               drop = 1'b1;
               report.outcome = OUT_SENT_REMOVE;
            end
         end else begin
            drop = (fails_inc >= cmd.max_fails);
            report.outcome = drop ? OUT_FAILS_DONE : OUT_FAIL_KEPT;
         end
      end
      link_out.found  = link_in.found || hit || take;
      link_out.remove = link_in.remove || hit || drop;
   end

   // Next contents of the slot.
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (link_out.remove) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (cmd.insert && is_tail) begin
         valid_in = 1'b1;
         entry_in = new_entry;
      end else if (report.deferred) begin
         entry_in.next_time = cmd.defer_time;
      end else if (take) begin
         entry_in.next_time = cmd.resend_time;
         if (cmd.send_ok) begin
            entry_in.fails = '0;
            entry_in.sends = sends_inc;
         end else begin
            entry_in.fails = fails_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         entry_ff <= entry_in;
      end
   end

`ifndef SYNTHESIS
   a_ack_only_valid : assert property (@(posedge clock) disable iff (reset)
      report.matched |-> valid_ff) else $error("ack matched an empty slot");
   a_no_both : assert property (@(posedge clock) disable iff (reset)
      !(report.sent && report.deferred)) else $error("slot both sent and deferred");
   a_shift_empty : assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> (link_out.found == link_in.found))
      else $error("empty slot claimed an item");
`endif

endmodule

[rtl/core/retransmit_queue_scheduler_core.sv]
// Top level of the retransmit queue scheduler: handshake, configuration
// registers, the chain of rqs_cell slots and the result register. Uses rqs_pkg.
//
//  channel  | ports                      | direction
//  req      | req_valid, req_stall, req_*| in, stall driven out
//  rsp      | rsp_valid, rsp_stall, rsp_*| out, stall driven in
//  csr      | csr_valid, csr_ready, ...  | in, ready always high
//
// The whole table is evaluated for each item through the cell chain, with
// the found/remove status rippling combinationally slot to slot.
// The result is held in an output register; a new item is taken while it is
// empty or being taken, so items flow at one per cycle while the receiver
// keeps up, and the input stalls while a waiting result is stalled.
// Synchronous active-high reset empties the table and restores the registers.
`timescale 1ns / 1ps
module retransmit_queue_scheduler_core
   import rqs_pkg::*;
#(
   parameter int TABLE_DEPTH = DefaultDepth
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [KindWidth-1:0]      req_kind,
   input  logic [SeqWidth-1:0]       req_seq_number,
   input  logic                      req_via_tcp,
   input  logic                      req_wants_ack,
   input  logic [TagWidth-1:0]       req_payload_tag,
   input  logic [TimeWidth-1:0]      req_now,
   input  logic                      req_link_up,
   input  logic                      req_udp_ready,
   input  logic                      req_tcp_ready,
   input  logic                      req_send_ok,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_accepted,
   output logic [OutcomeWidth-1:0]   rsp_outcome,
   output logic [SeqWidth-1:0]       rsp_sent_seq,
   output logic [TagWidth-1:0]       rsp_sent_tag,
   output logic                      rsp_sent_via_tcp,
   output logic [ResultCntWidth-1:0] rsp_deferred_count,
   output logic [ResultCntWidth-1:0] rsp_entries_in_use,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [IntervalWidth-1:0]  csr_data
);

   localparam int OccWidth = $clog2(TABLE_DEPTH + 1);

   logic [IntervalWidth-1:0] interval_ff;
   logic [CountWidth-1:0]    max_sends_ff, max_fails_ff;
   logic [OccWidth-1:0]      occ_ff, occ_in;
   logic                     step, full;
   kind_type                 kind;
   cmd_type                  cmd;
   entry_type                new_entry;

   link_type   links   [TABLE_DEPTH+1];
   logic       valids  [TABLE_DEPTH+1];
   entry_type  entries [TABLE_DEPTH+1];
   report_type reports [TABLE_DEPTH];

   logic                      rsp_valid_ff;
   logic                      acc_ff, acc_in;
   logic [OutcomeWidth-1:0]   outc_ff, outc_in;
   logic [SeqWidth-1:0]       sseq_ff, sseq_in;
   logic [TagWidth-1:0]       stag_ff, stag_in;
   logic                      stcp_ff, stcp_in;
   logic [ResultCntWidth-1:0] defc_ff, defc_in;
   logic [OccWidth-1:0]       defer_sum;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;
   assign kind      = kind_type'(req_kind);
   assign full      = (occ_ff == OccWidth'(TABLE_DEPTH));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= ResetResendInterval;
         max_sends_ff <= ResetMaxSendCount;
         max_fails_ff <= ResetMaxFailCount;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RESEND_INTERVAL: interval_ff  <= csr_data;
            CSR_MAX_SEND_COUNT:  max_sends_ff <= csr_data[CountWidth-1:0];
            CSR_MAX_FAIL_COUNT:  max_fails_ff <= csr_data[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // Broadcast command for the chain.
   always_comb begin
      cmd.insert      = (kind == KIND_INSERT) && !full;
      cmd.ack         = (kind == KIND_ACK);
      cmd.tick        = (kind == KIND_TICK) && req_link_up;
      cmd.seq         = req_seq_number;
      cmd.now         = req_now;
      cmd.udp_ready   = req_udp_ready;
      cmd.tcp_ready   = req_tcp_ready;
      cmd.send_ok     = req_send_ok;
      cmd.defer_time  = req_now + TimeWidth'(interval_ff >> 1);
      cmd.resend_time = req_now + TimeWidth'(interval_ff);
      cmd.max_sends   = max_sends_ff;
      cmd.max_fails   = max_fails_ff;
      new_entry.seq       = req_seq_number;
      new_entry.tag       = req_payload_tag;
      new_entry.tcp       = req_via_tcp;
      new_entry.ack       = req_wants_ack;
      new_entry.next_time = '0;
      new_entry.sends     = '0;
      new_entry.fails     = '0;
   end

   // The chain of slots; the end of the chain shifts in an empty slot.
   assign links[0]             = '0;
   assign valids[TABLE_DEPTH]  = 1'b0;
   assign entries[TABLE_DEPTH] = new_entry;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      rqs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .step       (step),
         .cmd        (cmd),
         .link_in    (links[g]),
         .is_tail    (occ_ff == OccWidth'(g)),
         .new_entry  (new_entry),
         .next_valid (valids[g+1]),
         .next_entry (entries[g+1]),
         .link_out   (links[g+1]),
         .valid      (valids[g]),
         .entry      (entries[g]),
         .report     (reports[g])
      );
   end

   // Gather the slot reports into one result.
   always_comb begin
      defer_sum = '0;
      outc_in   = OUT_NONE;
      sseq_in   = '0;
      stag_in   = '0;
      stcp_in   = 1'b0;
      acc_in    = cmd.insert;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         defer_sum = defer_sum + OccWidth'(reports[i].deferred);
         if (reports[i].matched) begin
            acc_in = 1'b1;
         end
         if (reports[i].sent) begin
            outc_in = reports[i].outcome;
            sseq_in = entries[i].seq;
            stag_in = entries[i].tag;
            stcp_in = entries[i].tcp;
            acc_in  = req_send_ok;
         end
      end
      if (outc_in == OUT_NONE && defer_sum != '0) begin
         outc_in = OUT_DEFERRED;
      end
      defc_in = ResultCntWidth'(defer_sum);
      occ_in  = occ_ff;
      if (cmd.insert) begin
         occ_in = occ_ff + 1'b1;
      end else if (links[TABLE_DEPTH].remove) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            occ_ff <= occ_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         acc_ff  <= acc_in;
         outc_ff <= outc_in;
         sseq_ff <= sseq_in;
         stag_ff <= stag_in;
         stcp_ff <= stcp_in;
         defc_ff <= defc_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = acc_ff;
   assign rsp_outcome        = outc_ff;
   assign rsp_sent_seq       = sseq_ff;
   assign rsp_sent_tag       = stag_ff;
   assign rsp_sent_via_tcp   = stcp_ff;
   assign rsp_deferred_count = defc_ff;
   assign rsp_entries_in_use = ResultCntWidth'(occ_ff);

`ifndef SYNTHESIS
   a_occ_range : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OccWidth'(TABLE_DEPTH)) else $error("occupancy beyond depth");
   a_occ_step : assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(occ_ff)) else $error("occupancy moved without an item");
   a_head_valid : assert property (@(posedge clock) disable iff (reset)
      (occ_ff != '0) |-> valids[0]) else $error("first slot empty in a non-empty table");
   a_sent_outcome : assert property (@(posedge clock) disable iff (reset)
      (step && !cmd.tick) |=> (rsp_outcome == OUT_NONE))
      else $error("non-tick item reported a send");
`endif

endmodule
